FILE: src/cbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbe_pkg;

   // channel format: signed fixed point, three integer bits
   localparam int CHAN_BITS = 16;
   localparam int FRAC_BITS = CHAN_BITS - 3;
   localparam int WIDE_BITS = 2 * CHAN_BITS + 2;
   localparam int KON_BITS  = 16;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LANES = 4;

   typedef logic signed [CHAN_BITS-1:0]   chan_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic signed [2*CHAN_BITS-1:0] prod_type;

   localparam chan_type FIX_ONE = chan_type'(1 << FRAC_BITS);
   localparam chan_type FIX_MAX = {1'b0, {(CHAN_BITS-1){1'b1}}};
   localparam chan_type FIX_MIN = {1'b1, {(CHAN_BITS-1){1'b0}}};
   localparam wide_type FIX_ONE_W = wide_type'(FIX_ONE);
   localparam wide_type FIX_MAX_W = wide_type'(FIX_MAX);
   localparam wide_type FIX_MIN_W = wide_type'(FIX_MIN);
   localparam wide_type FIX_HALF_W = wide_type'(1 << (FRAC_BITS - 1));

   // blend function codes
   localparam logic [2:0] FN_ADD  = 3'd0;
   localparam logic [2:0] FN_SUB  = 3'd1;
   localparam logic [2:0] FN_RSUB = 3'd2;
   localparam logic [2:0] FN_MIN  = 3'd3;
   localparam logic [2:0] FN_MAX  = 3'd4;

   // base factor codes, bit 4 inverts
   localparam int         FCT_INV_BIT   = 4;
   localparam logic [3:0] FCT_ONE       = 4'd1;
   localparam logic [3:0] FCT_SRC       = 4'd2;
   localparam logic [3:0] FCT_SRC_A     = 4'd3;
   localparam logic [3:0] FCT_DST_A     = 4'd4;
   localparam logic [3:0] FCT_DST       = 4'd5;
   localparam logic [3:0] FCT_ALPHA_SAT = 4'd6;
   localparam logic [3:0] FCT_CONST     = 4'd7;
   localparam logic [3:0] FCT_CONST_A   = 4'd8;
   localparam logic [3:0] FCT_SRC1      = 4'd9;
   localparam logic [3:0] FCT_SRC1_A    = 4'd10;

   // target format kinds
   localparam logic [1:0] FMT_UNORM = 2'd1;
   localparam logic [1:0] FMT_SNORM = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FUNCS     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RGB_SRC   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RGB_DST   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_SRC = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_DST = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTANT  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORMAT    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_CHANS = 3'd7;

   typedef struct packed {
      logic [5:0]  blend_functions;
      logic [4:0]  color_src_sel;
      logic [4:0]  color_dst_sel;
      logic [4:0]  alpha_src_sel;
      logic [4:0]  alpha_dst_sel;
      logic [CSR_DATA_BITS-1:0] blend_constant;
      logic [1:0]  format_class;
      logic [2:0]  dst_channels;
   } cfg_type;

   typedef struct packed {
      logic [2:0] func;
      logic [4:0] src_code;
      logic [4:0] dst_code;
      logic       is_alpha;
   } lane_ctl_type;

   typedef struct packed {
      chan_type src_red;
      chan_type src_green;
      chan_type src_blue;
      chan_type src_alpha;
      chan_type dst_red;
      chan_type dst_green;
      chan_type dst_blue;
      chan_type dst_alpha;
   } req_type;

   typedef struct packed {
      chan_type out_red;
      chan_type out_green;
      chan_type out_blue;
      chan_type out_alpha;
   } rsp_type;

   function automatic wide_type widen(input chan_type v);
      return wide_type'(v);
   endfunction

   function automatic chan_type sat_chan(input wide_type v);
      chan_type r;
      if (v > FIX_MAX_W) begin
         r = FIX_MAX;
      end else if (v < FIX_MIN_W) begin
         r = FIX_MIN;
      end else begin
         r = v[CHAN_BITS-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/cbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cbe_front (
   input  wire logic          clock,
   input  wire cbe_pkg::cfg_type cfg,
   input  wire cbe_pkg::req_type req,
   output cbe_pkg::chan_type  src_ff [cbe_pkg::LANES],
   output cbe_pkg::chan_type  dst_ff [cbe_pkg::LANES],
   output cbe_pkg::chan_type  kon_ff [cbe_pkg::LANES]
);
   import cbe_pkg::*;

   chan_type src_in [LANES];
   chan_type dst_in [LANES];
   chan_type kon_in [LANES];
   chan_type kon_raw [LANES];
   chan_type src_raw [LANES];

   function automatic chan_type fmt_clamp(input chan_type v, input logic [1:0] fmt);
      chan_type r;
      r = v;
      if (fmt == FMT_UNORM) begin
         if (v < 0) r = '0;
         else if (v > FIX_ONE) r = FIX_ONE;
      end else if (fmt == FMT_SNORM) begin
         if (v < -FIX_ONE) r = -FIX_ONE;
         else if (v > FIX_ONE) r = FIX_ONE;
      end
      return r;
   endfunction

   assign src_raw[0] = req.src_red;
   assign src_raw[1] = req.src_green;
   assign src_raw[2] = req.src_blue;
   assign src_raw[3] = req.src_alpha;

   // constant fields are 16 bits, rescaled to the channel width
   for (genvar c = 0; c < LANES; c++) begin : g_kon
      logic signed [KON_BITS-1:0] field;
      assign field = cfg.blend_constant[KON_BITS*c +: KON_BITS];
      if (CHAN_BITS >= KON_BITS) begin : g_up
         assign kon_raw[c] = chan_type'(field) <<< (CHAN_BITS - KON_BITS);
      end else begin : g_down
         logic signed [KON_BITS-1:0] shifted;
         assign shifted = field >>> (KON_BITS - CHAN_BITS);
         assign kon_raw[c] = shifted[CHAN_BITS-1:0];
      end
   end

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         src_in[c] = fmt_clamp(src_raw[c], cfg.format_class);
         kon_in[c] = fmt_clamp(kon_raw[c], cfg.format_class);
      end
      // absent target channels: colour reads zero, alpha reads one
      dst_in[0] = req.dst_red;
      dst_in[1] = (cfg.dst_channels <= 3'd1) ? '0 : req.dst_green;
      dst_in[2] = (cfg.dst_channels <= 3'd2) ? '0 : req.dst_blue;
      dst_in[3] = (cfg.dst_channels < 3'd4) ? FIX_ONE : req.dst_alpha;
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
      kon_ff <= kon_in;
   end

endmodule
`default_nettype wire

FILE: src/cbe_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module cbe_lane (
   input  wire logic                  clock,
   input  wire cbe_pkg::lane_ctl_type ctl,
   input  wire cbe_pkg::chan_type     src_own,
   input  wire cbe_pkg::chan_type     src_alpha,
   input  wire cbe_pkg::chan_type     dst_own,
   input  wire cbe_pkg::chan_type     dst_alpha,
   input  wire cbe_pkg::chan_type     kon_own,
   input  wire cbe_pkg::chan_type     kon_alpha,
   output cbe_pkg::chan_type          res_ff
);
   import cbe_pkg::*;

   chan_type a2_ff, b2_ff, sf2_ff, df2_ff;
   chan_type a2_in, b2_in, sf2_in, df2_in;
   chan_type a3_ff, b3_ff;
   prod_type pa3_ff, pb3_ff;
   prod_type pa3_in, pb3_in;
   wide_type ra_w, rb_w, comb_w;
   chan_type ra, rb, x, y;
   chan_type res_in;

   function automatic chan_type pick_factor(
      input logic [4:0] code,
      input logic       is_alpha,
      input chan_type   s_own,
      input chan_type   s_a,
      input chan_type   d_own,
      input chan_type   d_a,
      input chan_type   k_own,
      input chan_type   k_a
   );
      chan_type base;
      chan_type one_minus_da;
      one_minus_da = sat_chan(FIX_ONE_W - widen(d_a));
      case (code[3:0]) inside
         FCT_ONE:       base = FIX_ONE;
         FCT_SRC:       base = s_own;
         FCT_SRC_A:     base = s_a;
         FCT_DST_A:     base = d_a;
         FCT_DST:       base = d_own;
         FCT_ALPHA_SAT: begin
            if (is_alpha) base = FIX_ONE;
            else base = (s_a < one_minus_da) ? s_a : one_minus_da;
         end
         FCT_CONST:     base = k_own;
         FCT_CONST_A:   base = k_a;
         // second-source factors are not present
         FCT_SRC1, FCT_SRC1_A: base = '0;
         default:       base = FIX_ONE;
      endcase
      if (code[FCT_INV_BIT]) begin
         base = sat_chan(FIX_ONE_W - widen(base));
      end
      return base;
   endfunction

   // factor selection
   always_comb begin
      a2_in  = src_own;
      b2_in  = dst_own;
      sf2_in = pick_factor(ctl.src_code, ctl.is_alpha, src_own, src_alpha,
                           dst_own, dst_alpha, kon_own, kon_alpha);
      df2_in = pick_factor(ctl.dst_code, ctl.is_alpha, src_own, src_alpha,
                           dst_own, dst_alpha, kon_own, kon_alpha);
   end

   always_ff @(posedge clock) begin
      a2_ff  <= a2_in;
      b2_ff  <= b2_in;
      sf2_ff <= sf2_in;
      df2_ff <= df2_in;
   end

   // scaling products
   assign pa3_in = a2_ff * sf2_ff;
   assign pb3_in = b2_ff * df2_ff;

   always_ff @(posedge clock) begin
      pa3_ff <= pa3_in;
      pb3_ff <= pb3_in;
      a3_ff  <= a2_ff;
      b3_ff  <= b2_ff;
   end

   // round half up, saturate, then the blend function (min and max use the unscaled operands)
   always_comb begin
      ra_w = (wide_type'(pa3_ff) + FIX_HALF_W) >>> FRAC_BITS;
      rb_w = (wide_type'(pb3_ff) + FIX_HALF_W) >>> FRAC_BITS;
      ra   = sat_chan(ra_w);
      rb   = sat_chan(rb_w);
      if (ctl.func < FN_MIN) begin
         x = ra;
         y = rb;
      end else begin
         x = a3_ff;
         y = b3_ff;
      end
      case (ctl.func)
         FN_ADD:  comb_w = widen(x) + widen(y);
         FN_SUB:  comb_w = widen(x) - widen(y);
         FN_RSUB: comb_w = widen(y) - widen(x);
         FN_MIN:  comb_w = (x < y) ? widen(x) : widen(y);
         FN_MAX:  comb_w = (x > y) ? widen(x) : widen(y);
         default: comb_w = widen(x) + widen(y);
      endcase
      res_in = sat_chan(comb_w);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule
`default_nettype wire

FILE: src/color_blend_equation_unit.sv
// pipeline: a taken pixel passes the front, factor, product and result registers
// and then appears on rsp_data with rsp_valid high for a single cycle
// throughput: one pixel per cycle, set by the four channel lanes each
// having one multiplier pair in their own pipeline stage; busy stays low
// reset (synchronous) restores all blend registers to their defaults
// and drops any beat still in flight; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module color_blend_equation_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire cbe_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   output cbe_pkg::rsp_type                           rsp_data,
   input  wire logic                                  csr_we,
   input  wire logic [cbe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [cbe_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import cbe_pkg::*;

   localparam int DEPTH = 4;

   cfg_type cfg_ff, cfg_in;
   logic [DEPTH-1:0] vld_ff, vld_in;
   chan_type src_c [LANES];
   chan_type dst_c [LANES];
   chan_type kon_c [LANES];
   chan_type res_c [LANES];
   lane_ctl_type lane_ctl [LANES];

   assign busy = 1'b0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FUNCS:     cfg_in.blend_functions = csr_wdata[5:0];
            CSR_RGB_SRC:   cfg_in.color_src_sel   = csr_wdata[4:0];
            CSR_RGB_DST:   cfg_in.color_dst_sel   = csr_wdata[4:0];
            CSR_ALPHA_SRC: cfg_in.alpha_src_sel   = csr_wdata[4:0];
            CSR_ALPHA_DST: cfg_in.alpha_dst_sel   = csr_wdata[4:0];
            CSR_CONSTANT:  cfg_in.blend_constant  = csr_wdata;
            CSR_FORMAT:    cfg_in.format_class    = csr_wdata[1:0];
            CSR_DST_CHANS: cfg_in.dst_channels    = csr_wdata[2:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_functions <= '0;
         cfg_ff.color_src_sel   <= 5'd1;
         cfg_ff.color_dst_sel   <= 5'd17;
         cfg_ff.alpha_src_sel   <= 5'd1;
         cfg_ff.alpha_dst_sel   <= 5'd17;
         cfg_ff.blend_constant  <= '0;
         cfg_ff.format_class    <= FMT_UNORM;
         cfg_ff.dst_channels    <= 3'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // beat tracking through the pipeline
   assign vld_in = {vld_ff[DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   cbe_front u_front (
      .clock  (clock),
      .cfg    (cfg_ff),
      .req    (req_data),
      .src_ff (src_c),
      .dst_ff (dst_c),
      .kon_ff (kon_c)
   );

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      localparam bit IS_ALPHA = (c == LANES - 1);
      always_comb begin
         lane_ctl[c].func     = IS_ALPHA ? cfg_ff.blend_functions[5:3]
                                         : cfg_ff.blend_functions[2:0];
         lane_ctl[c].src_code = IS_ALPHA ? cfg_ff.alpha_src_sel : cfg_ff.color_src_sel;
         lane_ctl[c].dst_code = IS_ALPHA ? cfg_ff.alpha_dst_sel : cfg_ff.color_dst_sel;
         lane_ctl[c].is_alpha = IS_ALPHA;
      end

      cbe_lane u_lane (
         .clock     (clock),
         .ctl       (lane_ctl[c]),
         .src_own   (src_c[c]),
         .src_alpha (src_c[LANES-1]),
         .dst_own   (dst_c[c]),
         .dst_alpha (dst_c[LANES-1]),
         .kon_own   (kon_c[c]),
         .kon_alpha (kon_c[LANES-1]),
         .res_ff    (res_c[c])
      );
   end

   // merge the lanes into one result beat
   assign rsp_valid         = vld_ff[DEPTH-1];
   assign rsp_data.out_red   = res_c[0];
   assign rsp_data.out_green = res_c[1];
   assign rsp_data.out_blue  = res_c[2];
   assign rsp_data.out_alpha = res_c[3];

   a_rsp_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, DEPTH))
      else $error("result beat without a pixel taken four cycles earlier");

   a_start_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##(DEPTH-1) rsp_valid)
      else $error("accepted pixel gave no result beat");

   a_unorm_src_range: assert property (@(posedge clock) disable iff (reset)
      ($past(cfg_ff.format_class) == FMT_UNORM) |->
         (src_c[0] >= 0 && src_c[0] <= FIX_ONE &&
          src_c[3] >= 0 && src_c[3] <= FIX_ONE))
      else $error("unorm source left the unit range");

   a_missing_alpha_one: assert property (@(posedge clock) disable iff (reset)
      ($past(cfg_ff.dst_channels) < 3'd4) |-> (dst_c[3] == FIX_ONE))
      else $error("absent target alpha did not read one");

endmodule
`default_nettype wire
